// File: rtl/core/rrbm_pkg.sv
`default_nettype none

package rrbm_pkg;

  localparam int MAX_ROM_BANKS_LOG2 = 7;
  localparam int MAX_RAM_BANKS      = 4;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int PHYS_W  = 21;
  localparam int CFG_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int ROM_SEL_W = 5;
  localparam int RAM_SEL_W = 2;
  localparam int BANK_W    = MAX_ROM_BANKS_LOG2;

  typedef enum logic [2:0] {
    TGT_ROM_READ  = 3'd0,
    TGT_RAM_READ  = 3'd1,
    TGT_RAM_WRITE = 3'd2,
    TGT_REG_WRITE = 3'd3,
    TGT_OPEN_BUS  = 3'd4
  } tgt_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_COUNT = 2'd1;

  // Address regions, top three address bits (8 KiB windows)
  localparam logic [2:0] REG_RAM_ENABLE = 3'd0;
  localparam logic [2:0] REG_ROM_BANK   = 3'd1;
  localparam logic [2:0] REG_RAM_BANK   = 3'd2;
  localparam logic [2:0] REG_MODE       = 3'd3;
  localparam logic [2:0] REGION_EXT_RAM = 3'd5;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

endpackage

`default_nettype wire

// File: rtl/core/rrbm_if.sv
`default_nettype none

interface rrbm_req_if;
  logic                             valid;
  logic                             ready;
  rrbm_pkg::cmd_t                   command;
  logic [rrbm_pkg::ADDR_W-1:0]      bus_address;
  logic [rrbm_pkg::DATA_W-1:0]      write_byte;

  modport source (output valid, command, bus_address, write_byte, input ready);
  modport sink   (input valid, command, bus_address, write_byte, output ready);
endinterface

interface rrbm_rsp_if;
  logic                             valid;
  logic                             ready;
  rrbm_pkg::tgt_t                   target;
  logic [rrbm_pkg::PHYS_W-1:0]      phys_address;
  logic [rrbm_pkg::DATA_W-1:0]      ram_write_data;

  modport source (output valid, target, phys_address, ram_write_data, input ready);
  modport sink   (input valid, target, phys_address, ram_write_data, output ready);
endinterface

interface rrbm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rrbm_pkg::CFG_IDX_W-1:0]   index;
  logic [rrbm_pkg::CFG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rom_ram_bank_mapper_top.sv
`default_nettype none

// Cartridge bank mapper: one bus access in, one translated word out.
// The result word of an accepted access is registered and shown on rsp in the next cycle.
// Throughput: one access per cycle while rsp.ready is high; set by the single result register.
// Reset (rst, synchronous): RAM disabled, ROM bank 1, RAM bank 0,
// two ROM banks, no RAM banks; no result word pending.
module rom_ram_bank_mapper_top (
  input  wire             clk,
  input  wire             rst,
  rrbm_req_if.sink        req,
  rrbm_rsp_if.source      rsp,
  rrbm_cfg_if.sink        cfg
);

  logic [rrbm_pkg::CFG_W-1:0]      rom_log2;
  logic [rrbm_pkg::CFG_W-1:0]      ram_count;
  logic                            ram_enable;
  logic [rrbm_pkg::ROM_SEL_W-1:0]  rom_sel;
  logic [rrbm_pkg::RAM_SEL_W-1:0]  ram_sel;

  logic                            rsp_valid;
  rrbm_pkg::tgt_t                  rsp_target;
  logic [rrbm_pkg::PHYS_W-1:0]     rsp_phys;
  logic [rrbm_pkg::DATA_W-1:0]     rsp_wdata;

  logic                            accept;
  logic [2:0]                      region;
  logic                            low_half;
  logic                            in_bank0;
  logic [rrbm_pkg::CFG_W-1:0]      lg_eff;
  logic [rrbm_pkg::CFG_W-1:0]      ram_count_eff;
  logic                            ram_usable;
  logic [rrbm_pkg::BANK_W-1:0]     bank_mask;
  logic [rrbm_pkg::BANK_W-1:0]     rom_bank;
  logic [rrbm_pkg::PHYS_W-1:0]     ram_phys;
  rrbm_pkg::tgt_t                  target_next;
  logic [rrbm_pkg::PHYS_W-1:0]     phys_next;
  logic [rrbm_pkg::DATA_W-1:0]     wdata_next;
  logic                            ram_enable_next;
  logic [rrbm_pkg::ROM_SEL_W-1:0]  rom_sel_next;
  logic [rrbm_pkg::RAM_SEL_W-1:0]  ram_sel_next;
  logic [rrbm_pkg::ROM_SEL_W-1:0]  rom_sel_raw;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid          = rsp_valid;
  assign rsp.target         = rsp_target;
  assign rsp.phys_address   = rsp_phys;
  assign rsp.ram_write_data = rsp_wdata;

  assign region   = req.bus_address[15:13];
  assign low_half = !req.bus_address[15];
  assign in_bank0 = !req.bus_address[15] && !req.bus_address[14];

  // Saturate the configured sizes into their legal ranges
  always_comb begin
    lg_eff = (rom_log2 == '0) ? rrbm_pkg::CFG_W'(1) : rom_log2;
    ram_count_eff = (ram_count > rrbm_pkg::CFG_W'(rrbm_pkg::MAX_RAM_BANKS))
                    ? rrbm_pkg::CFG_W'(rrbm_pkg::MAX_RAM_BANKS) : ram_count;
  end

  assign ram_usable = ram_enable &&
                      ({1'b0, ram_sel} < ram_count_eff);
  assign bank_mask  = rrbm_pkg::BANK_W'((8'd1 << lg_eff) - 8'd1);
  assign rom_bank   = rrbm_pkg::BANK_W'(rom_sel) & bank_mask;
  assign ram_phys   = {{(rrbm_pkg::PHYS_W - rrbm_pkg::RAM_SEL_W - 13){1'b0}},
                       ram_sel, req.bus_address[12:0]};
  assign rom_sel_raw = req.write_byte[rrbm_pkg::ROM_SEL_W-1:0];

  always_comb begin
    target_next     = rrbm_pkg::TGT_OPEN_BUS;
    phys_next       = '0;
    wdata_next      = '0;
    ram_enable_next = ram_enable;
    rom_sel_next    = rom_sel;
    ram_sel_next    = ram_sel;
    if (req.command == rrbm_pkg::CMD_WRITE) begin
      if (low_half) begin
        target_next = rrbm_pkg::TGT_REG_WRITE;
        unique case (region)
          rrbm_pkg::REG_RAM_ENABLE: begin
            ram_enable_next = (req.write_byte[3:0] == rrbm_pkg::RAM_ENABLE_KEY);
          end
          rrbm_pkg::REG_ROM_BANK: begin
            // bank zero maps to bank one
            rom_sel_next = (rom_sel_raw == '0) ? rrbm_pkg::ROM_SEL_W'(1) : rom_sel_raw;
          end
          rrbm_pkg::REG_RAM_BANK: begin
            ram_sel_next = req.write_byte[rrbm_pkg::RAM_SEL_W-1:0];
          end
          default: begin
            // mode register: no effect
          end
        endcase
      end else if (region == rrbm_pkg::REGION_EXT_RAM && ram_usable) begin
        target_next = rrbm_pkg::TGT_RAM_WRITE;
        phys_next   = ram_phys;
        wdata_next  = req.write_byte;
      end
    end else begin
      priority if ((lg_eff == rrbm_pkg::CFG_W'(1) && low_half) || in_bank0) begin
        target_next = rrbm_pkg::TGT_ROM_READ;
        phys_next   = rrbm_pkg::PHYS_W'(req.bus_address);
      end else if (low_half) begin
        target_next = rrbm_pkg::TGT_ROM_READ;
        phys_next   = {rom_bank, req.bus_address[13:0]};
      end else if (region == rrbm_pkg::REGION_EXT_RAM && ram_usable) begin
        target_next = rrbm_pkg::TGT_RAM_READ;
        phys_next   = ram_phys;
      end else begin
        target_next = rrbm_pkg::TGT_OPEN_BUS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_log2 <= rrbm_pkg::CFG_W'(1);
      ram_count <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == rrbm_pkg::CFG_ROM_LOG2) begin
        rom_log2 <= cfg.data;
      end else if (cfg.index == rrbm_pkg::CFG_RAM_COUNT) begin
        ram_count <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable <= 1'b0;
      rom_sel    <= rrbm_pkg::ROM_SEL_W'(1);
      ram_sel    <= '0;
    end else if (accept) begin
      ram_enable <= ram_enable_next;
      rom_sel    <= rom_sel_next;
      ram_sel    <= ram_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // hold the word until taken; load a new one on each accepted access
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_target <= target_next;
      rsp_phys   <= phys_next;
      rsp_wdata  <= wdata_next;
    end
  end

endmodule

`default_nettype wire
